// ===== hw/rtl/bni_pkg.sv =====
`default_nettype none

package bni_pkg;

  // Field widths of one beat
  localparam int ChanW = 6;
  localparam int DataW = 16;

  // Shared compare-subtract unit, wide enough for the square-root remainder
  localparam int SubW = 28;

  // Shared multiplier: table multiplier times a Q7.8 operand
  localparam int MulAw = 32;
  localparam int MulBw = 16;
  localparam int ProdW = MulAw + MulBw;

  // Stream payload widths, zero filled to whole bytes
  localparam int InDataW  = 88;
  localparam int OutDataW = 24;

  // Request kinds carried in s_axis_tuser
  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqSample = 1'b1;

  // Multiplier saturation values
  localparam logic signed [MulAw-1:0] MultMax = 32'sh7FFF_FFFF;
  localparam logic signed [MulAw-1:0] MultMin = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] offset;  // Q15.16
    logic signed [31:0] mult;    // Q15.16
  } tbl_entry_t;

  typedef struct packed {
    logic [SubW-1:0] diff;
    logic            ge;
  } sub_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bni_cmp_sub.sv =====
`default_nettype none

// Compare and subtract: one restoring step of the root or the divide.
module bni_cmp_sub import bni_pkg::*; (
  input  logic [SubW-1:0] a_i,
  input  logic [SubW-1:0] b_i,
  output sub_res_t        res_o
);

  logic [SubW:0] diff;

  assign diff       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff = diff[SubW-1:0];
  assign res_o.ge   = ~diff[SubW];

endmodule

`default_nettype wire

// ===== hw/rtl/bni_mult.sv =====
`default_nettype none

// Registered signed multiplier, shared by parameter loads and samples.
module bni_mult import bni_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [MulAw-1:0] a_i,
  input  logic signed [MulBw-1:0] b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bni_param_mem.sv =====
`default_nettype none

// Per-channel multiplier and offset table. An entry never written reads as
// invalid, which the caller treats as all zero.
module bni_param_mem import bni_pkg::*; #(
  parameter int Depth = 64,
  parameter int Aw    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  tbl_entry_t    wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output tbl_entry_t    rdata_o,
  output logic          rvalid_o
);

  tbl_entry_t       mem_q [Depth];
  tbl_entry_t       rdata_q;
  logic [Depth-1:0] vld_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/batch_norm_inference_unit.sv =====
`default_nettype none

// Per-channel batch normalization for inference, in fixed point. A beat with
// s_axis_tuser low loads one channel: the unit forms gain/sqrt(variance+eps)
// as a Q15.16 multiplier and bias - multiplier*average as a Q15.16 offset and
// stores both in the channel table; it returns nothing. A load runs through
// accept, bit-serial square root, a setup step and bit-serial restoring divide
// on one shared compare-subtract unit, then the shared multiplier, then forms
// and stores the offset; when variance+eps is zero it skips from accept
// straight to the multiplier. A beat with s_axis_tuser high normalizes a
// sample and returns one beat: multiplier*sample+offset rounded to Q7.8,
// saturated to 16 bits, with the clip flag in m_axis_tuser. A sample steps
// through accept, table read, multiply, round/saturate into the output
// register. One beat is worked on at a time and s_axis_tready is high only
// while the sequencer is idle; a result waiting in the output register does
// not hold off the next input beat. The table resets to all zero. Channels at
// or beyond MAX_CHANNELS are ignored on load and give zero on a sample. Write
// eps (unsigned Q8.8, reset 1) through cfg_we_i/cfg_wdata_i only while idle.
module batch_norm_inference_unit import bni_pkg::*; #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [DataW-1:0]    cfg_wdata_i,    // eps_floor
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [5:0] chan_idx, [21:6] gain_in, [37:22] bias_in, [53:38] avg_in,
  // [69:54] spread_in, [85:70] sample_in, [87:86] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,   // [0] req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] norm_out, [21:16] chan_out, [23:22] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tuser    // [0] sat_flag
);

  // Only the channels that chan_idx can address get a table entry.
  localparam int TblDepth = (MAX_CHANNELS < (1 << ChanW)) ? MAX_CHANNELS : (1 << ChanW);
  localparam int TblAw    = (TblDepth > 1) ? $clog2(TblDepth) : 1;
  localparam logic [ChanW:0] TblDepthW = (ChanW + 1)'(TblDepth);

  // Sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSqrt  = 4'd1;
  localparam logic [3:0] StPrep  = 4'd2;
  localparam logic [3:0] StDiv   = 4'd3;
  localparam logic [3:0] StMult  = 4'd4;
  localparam logic [3:0] StOffs  = 4'd5;
  localparam logic [3:0] StSRead = 4'd6;
  localparam logic [3:0] StSMult = 4'd7;
  localparam logic [3:0] StSOut  = 4'd8;

  localparam logic [5:0] SqrtLast = 6'd24;  // 25 root bits
  localparam logic [5:0] DivLast  = 6'd43;  // 44 dividend bits

  // Control state
  logic [3:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [DataW-1:0] eps_q;
  logic        m_valid_q, m_valid_d;

  // Beat fields held for the length of the work
  logic              chan_ok_q, chan_ok_d;
  logic [ChanW-1:0]  chan_q, chan_d;
  logic signed [DataW-1:0] gain_q, gain_d;
  logic signed [DataW-1:0] bias_q, bias_d;
  logic signed [DataW-1:0] avg_q, avg_d;
  logic signed [DataW-1:0] sample_q, sample_d;

  // Root and divide working registers
  logic [49:0] wk_q, wk_d;      // radicand, then dividend/quotient shift line
  logic [24:0] root_q, root_d;  // square root, then divisor
  logic [25:0] rem_q, rem_d;
  logic signed [MulAw-1:0] mult_q, mult_d;

  // Output register
  logic [DataW-1:0] norm_q, norm_d;
  logic [ChanW-1:0] ochan_q, ochan_d;
  logic             sat_q, sat_d;

  // Beat fields
  logic              in_acc;
  logic [ChanW-1:0]  in_chan;
  logic [DataW-1:0]  in_spread;
  logic [16:0]       spr_sum;
  logic              in_chan_ok;

  // Shared units
  logic [SubW-1:0]         sub_a, sub_b;
  sub_res_t                sub_res;
  logic                    mul_en;
  logic signed [MulAw-1:0] mul_a;
  logic signed [MulBw-1:0] mul_b;
  logic signed [ProdW-1:0] prod;

  // Table
  logic              tbl_we, tbl_re, tbl_rvalid, tbl_ok;
  tbl_entry_t        tbl_wdata, tbl_rdata;
  logic [TblAw-1:0]  tbl_addr;

  // Datapath helpers
  logic [DataW-1:0]  gain_mag;
  logic [43:0]       div_num;
  logic [27:0]       quot;
  logic signed [48:0] rnd_sum;
  logic signed [41:0] off_full;
  logic signed [31:0] off_sat;
  logic signed [MulAw-1:0] tbl_mult, tbl_off;
  logic signed [49:0] acc;
  logic [33:0]       y;

  assign in_acc     = s_axis_tvalid & s_axis_tready;
  assign in_chan    = s_axis_tdata[5:0];
  assign in_spread  = s_axis_tdata[69:54];
  assign spr_sum    = {1'b0, in_spread} + {1'b0, eps_q};
  assign in_chan_ok = ({1'b0, in_chan} < TblDepthW);

  assign s_axis_tready = (state_q == StIdle);

  assign tbl_addr = chan_q[TblAw-1:0];
  assign tbl_ok   = tbl_rvalid & chan_ok_q;
  assign tbl_mult = tbl_ok ? tbl_rdata.mult : '0;
  assign tbl_off  = tbl_ok ? tbl_rdata.offset : '0;

  // |gain| fits 16 unsigned bits, including the most negative gain.
  assign gain_mag = gain_q[DataW-1] ? (~gain_q + 16'd1) : gain_q;
  // Dividend |g|*2^28 + r/2 for round-to-nearest on the quotient.
  assign div_num  = {gain_mag, 28'd0} + {20'd0, root_q[24:1]};
  // Last quotient bit joins the low 27 bits already shifted in.
  assign quot     = {wk_q[26:0], sub_res.ge};

  // Offset: bias*2^8 minus mult*avg rounded to Q15.16, saturated to 32 bits.
  assign rnd_sum  = 49'(prod) + 49'sd128;
  assign off_full = 42'($signed({bias_q, 8'h00})) - 42'($signed(rnd_sum[48:8]));
  always_comb begin
    if ((&off_full[41:31]) | ~(|off_full[41:31])) begin
      off_sat = off_full[31:0];
    end else begin
      off_sat = off_full[41] ? MultMin : MultMax;
    end
  end

  // Sample: mult*x + offset*2^8, round to Q7.8 with ties upward.
  assign acc = 50'(prod) + 50'($signed({tbl_off, 8'h00})) + 50'sd32768;
  assign y   = acc[49:16];

  assign tbl_wdata.offset = off_sat;
  assign tbl_wdata.mult   = mult_q;

  // Shared compare-subtract operands: root step or divide step
  always_comb begin
    if (state_q == StSqrt) begin
      sub_a = {rem_q, wk_q[49:48]};
      sub_b = {1'b0, root_q, 2'b01};
    end else begin
      sub_a = {2'b00, rem_q[24:0], wk_q[43]};
      sub_b = {3'b000, root_q};
    end
  end

  // Shared multiplier operands: mult*avg on load, mult*sample on sample
  always_comb begin
    mul_en = (state_q == StMult) | (state_q == StSMult);
    if (state_q == StMult) begin
      mul_a = mult_q;
      mul_b = avg_q;
    end else begin
      mul_a = tbl_mult;
      mul_b = sample_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q;
    chan_ok_d = chan_ok_q;
    chan_d    = chan_q;
    gain_d    = gain_q;
    bias_d    = bias_q;
    avg_d     = avg_q;
    sample_d  = sample_q;
    wk_d      = wk_q;
    root_d    = root_q;
    rem_d     = rem_q;
    mult_d    = mult_q;
    norm_d    = norm_q;
    ochan_d   = ochan_q;
    sat_d     = sat_q;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;

    // Drop the result once the sink takes it.
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          chan_ok_d = in_chan_ok;
          chan_d    = in_chan;
          gain_d    = s_axis_tdata[21:6];
          bias_d    = s_axis_tdata[37:22];
          avg_d     = s_axis_tdata[53:38];
          sample_d  = s_axis_tdata[85:70];
          wk_d      = {1'b0, spr_sum, 32'd0};
          root_d    = '0;
          rem_d     = '0;
          cnt_d     = SqrtLast;
          if (s_axis_tuser == ReqSample) begin
            state_d = StSRead;
          end else if (in_chan_ok) begin
            if (spr_sum == 17'd0) begin
              // No root to divide by: saturate by the sign of the gain.
              if (s_axis_tdata[21]) begin
                mult_d = MultMin;
              end else if (s_axis_tdata[21:6] != 16'd0) begin
                mult_d = MultMax;
              end else begin
                mult_d = '0;
              end
              state_d = StMult;
            end else begin
              state_d = StSqrt;
            end
          end
        end
      end
      StSqrt: begin
        // One root bit per cycle: try (root<<2)|1 against the remainder.
        rem_d  = sub_res.ge ? sub_res.diff[25:0] : sub_a[25:0];
        root_d = {root_q[23:0], sub_res.ge};
        wk_d   = {wk_q[47:0], 2'b00};
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        wk_d    = {6'd0, div_num};
        rem_d   = '0;
        cnt_d   = DivLast;
        state_d = StDiv;
      end
      StDiv: begin
        // One quotient bit per cycle, shifted in behind the dividend.
        rem_d = {1'b0, sub_res.ge ? sub_res.diff[24:0] : sub_a[24:0]};
        wk_d  = {wk_q[48:0], sub_res.ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          // The quotient stays below 2^28 since the root is at least 2^16.
          mult_d  = gain_q[DataW-1] ? -$signed({4'd0, quot}) : $signed({4'd0, quot});
          state_d = StMult;
        end
      end
      StMult: begin
        state_d = StOffs;
      end
      StOffs: begin
        tbl_we  = 1'b1;
        state_d = StIdle;
      end
      StSRead: begin
        tbl_re  = chan_ok_q;
        state_d = StSMult;
      end
      StSMult: begin
        state_d = StSOut;
      end
      StSOut: begin
        // Hold until the output register is free.
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          ochan_d   = chan_q;
          if (!y[33] && (|y[32:15])) begin
            norm_d = 16'h7FFF;
            sat_d  = 1'b1;
          end else if (y[33] && !(&y[32:15])) begin
            norm_d = 16'h8000;
            sat_d  = 1'b1;
          end else begin
            norm_d = y[15:0];
            sat_d  = 1'b0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      eps_q     <= 16'd1;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chan_ok_q <= chan_ok_d;
    chan_q    <= chan_d;
    gain_q    <= gain_d;
    bias_q    <= bias_d;
    avg_q     <= avg_d;
    sample_q  <= sample_d;
    wk_q      <= wk_d;
    root_q    <= root_d;
    rem_q     <= rem_d;
    mult_q    <= mult_d;
    norm_q    <= norm_d;
    ochan_q   <= ochan_d;
    sat_q     <= sat_d;
  end

  bni_cmp_sub u_cmp_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  bni_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bni_param_mem #(
    .Depth (TblDepth),
    .Aw    (TblAw)
  ) u_param_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (tbl_we),
    .waddr_i  (tbl_addr),
    .wdata_i  (tbl_wdata),
    .re_i     (tbl_re),
    .raddr_i  (tbl_addr),
    .rdata_o  (tbl_rdata),
    .rvalid_o (tbl_rvalid)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, ochan_q, norm_q};
  assign m_axis_tuser  = sat_q;

endmodule

`default_nettype wire

// ===== sim/tb_batch_norm_inference_unit.sv =====
module tb_batch_norm_inference_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bni_pkg::*;

  // Leave margin for a trailing load to finish before touching eps
  localparam int LoadQuiet  = 100;
  // Long receiver hold-off that backs the unit up into its input
  localparam int HoldCycles = 300;
  // Random beats per eps setting
  localparam int RandBeats  = 285;

  typedef enum logic {RowCfg, RowBeat} row_kind_e;

  // One row of the stimulus table: either an eps write or a beat
  typedef struct {
    row_kind_e          kind;
    logic               req;
    logic [ChanW-1:0]   chan;
    logic signed [15:0] gain;
    logic signed [15:0] bias;
    logic signed [15:0] avg;
    logic [15:0]        spread;
    logic signed [15:0] smp;
    logic [15:0]        eps;
    bit                 typed;   // result typed in by hand
    logic signed [15:0] t_norm;
    logic               t_sat;
  } stim_row_t;

  typedef struct packed {
    logic signed [15:0] norm;
    logic [ChanW-1:0]   chan;
    logic               sat;
  } norm_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [DataW-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // Shadow of the unit's state: eps and the per-channel tables
  logic [15:0]        eps_now;
  logic signed [31:0] chan_mult   [64];
  logic signed [31:0] chan_offset [64];

  norm_res_t pending_norm[$];
  stim_row_t stim_tbl[$];

  int err_count      = 0;
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  bit calm           = 1'b0;
  bit hold_req       = 1'b0;

  batch_norm_inference_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Exact floor square root, digit by digit
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > longint'(MultMax)) return MultMax;
    if (v < longint'(MultMin)) return MultMin;
    return v[31:0];
  endfunction

  // Load one channel: multiplier = gain/sqrt(var+eps), offset = bias - mult*avg
  task automatic load_chan(input logic [ChanW-1:0] chan, input logic signed [15:0] gain,
                           input logic signed [15:0] bias, input logic signed [15:0] avg,
                           input logic [15:0] spread);
    longint unsigned s, r, mag, q;
    longint          g, m, prod;
    g = gain;
    s = longint'(spread) + longint'(eps_now);
    r = root_floor(s << 32);
    if (r == 0) begin
      // variance plus eps is zero: pin the multiplier by the sign of the gain
      m = (g > 0) ? longint'(MultMax) : ((g < 0) ? longint'(MultMin) : 0);
    end else begin
      mag = (g < 0) ? -g : g;
      q   = ((mag << 28) + (r >> 1)) / r;
      m   = (g < 0) ? -longint'(q) : longint'(q);
    end
    chan_mult[chan]   = clip32(m);
    prod              = longint'(chan_mult[chan]) * longint'(avg);
    chan_offset[chan] = clip32(longint'(bias) * 256 - ((prod + 128) >>> 8));
  endtask

  function automatic norm_res_t predict_norm(input logic [ChanW-1:0] chan,
                                             input logic signed [15:0] x);
    longint    acc, y;
    norm_res_t res;
    acc      = longint'(chan_mult[chan]) * longint'(x) + longint'(chan_offset[chan]) * 256;
    y        = (acc + 32768) >>> 16;
    res.chan = chan;
    res.sat  = 1'b0;
    if (y > 32767) begin
      y       = 32767;
      res.sat = 1'b1;
    end else if (y < -32768) begin
      y       = -32768;
      res.sat = 1'b1;
    end
    res.norm = y[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus table helpers
  // ---------------------------------------------------------------------

  function automatic stim_row_t blank_row();
    stim_row_t r;
    r = '{kind: RowBeat, req: ReqSample, chan: '0, gain: '0, bias: '0, avg: '0,
          spread: '0, smp: '0, eps: '0, typed: 1'b0, t_norm: '0, t_sat: 1'b0};
    return r;
  endfunction

  task automatic add_load(input logic [ChanW-1:0] chan, input logic [15:0] gain,
                          input logic [15:0] bias, input logic [15:0] avg,
                          input logic [15:0] spread);
    stim_row_t r;
    r        = blank_row();
    r.req    = ReqLoad;
    r.chan   = chan;
    r.gain   = gain;
    r.bias   = bias;
    r.avg    = avg;
    r.spread = spread;
    r.smp    = 16'h5A5A;
    stim_tbl.push_back(r);
  endtask

  // Sample row; typed marks a hand-written result
  task automatic add_sample(input logic [ChanW-1:0] chan, input logic [15:0] x,
                            input bit typed = 1'b0, input logic [15:0] norm = '0,
                            input logic sat = 1'b0);
    stim_row_t r;
    r        = blank_row();
    r.chan   = chan;
    r.smp    = x;
    r.gain   = 16'hA5A5;
    r.spread = 16'h3C3C;
    r.typed  = typed;
    r.t_norm = norm;
    r.t_sat  = sat;
    stim_tbl.push_back(r);
  endtask

  task automatic add_eps(input logic [15:0] eps);
    stim_row_t r;
    r      = blank_row();
    r.kind = RowCfg;
    r.eps  = eps;
    stim_tbl.push_back(r);
  endtask

  // Random beat: mostly samples, some loads; zero_bias steers spread to zero
  function automatic stim_row_t random_beat(input bit zero_bias);
    stim_row_t r;
    r        = blank_row();
    r.req    = ($urandom_range(99) < 15) ? ReqLoad : ReqSample;
    r.chan   = ChanW'($urandom_range(63));
    r.bias   = 16'($urandom_range(16'hFFFF));
    r.avg    = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(3))
      0:       r.gain = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
      1:       r.gain = 16'($signed($urandom_range(2048)) - 1024);
      default: r.gain = 16'($urandom_range(16'hFFFF));
    endcase
    case ($urandom_range(3))
      0:       r.spread = zero_bias ? 16'h0000 : 16'($urandom_range(3));
      1:       r.spread = 16'hFFFF;
      default: r.spread = 16'($urandom_range(16'hFFFF));
    endcase
    if ($urandom_range(3) == 0) r.smp = 16'($signed($urandom_range(1024)) - 512);
    else                        r.smp = 16'($urandom_range(16'hFFFF));
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Offer one beat, hold it until taken, then predict; maybe idle afterward
  task automatic drive_beat(input stim_row_t r);
    norm_res_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.req;
    s_axis_tdata  <= {2'b00, r.smp, r.spread, r.avg, r.bias, r.gain, r.chan};
    do @(posedge clk_i); while (!s_axis_tready);
    if (r.req == ReqLoad) begin
      load_chan(r.chan, r.gain, r.bias, r.avg, r.spread);
    end else begin
      if (r.typed) want = '{norm: r.t_norm, chan: r.chan, sat: r.t_sat};
      else         want = predict_norm(r.chan, r.smp);
      pending_norm.push_back(want);
    end
    if (!calm && $urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk_i);
    end
  endtask

  // Drain, let a trailing load finish, then write eps
  task automatic write_eps(input logic [15:0] eps);
    s_axis_tvalid <= 1'b0;
    while (pending_norm.size() != 0) @(posedge clk_i);
    repeat (LoadQuiet) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= eps;
    @(posedge clk_i);
    eps_now   = eps;
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(99) < sink_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat against the oldest pending one
  always @(posedge clk_i) begin : check_results
    norm_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_norm.size() == 0) begin
        report($sformatf("result beat with nothing pending: tdata %h", m_axis_tdata));
      end else begin
        want = pending_norm.pop_front();
        if (m_axis_tdata[15:0] !== want.norm)
          report($sformatf("chan %0d norm_out %h, want %h", want.chan,
                           m_axis_tdata[15:0], want.norm));
        if (m_axis_tdata[21:16] !== want.chan)
          report($sformatf("chan_out %0d, want %0d", m_axis_tdata[21:16], want.chan));
        if (m_axis_tuser !== want.sat)
          report($sformatf("chan %0d sat_flag %b, want %b", want.chan,
                           m_axis_tuser, want.sat));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [15:0] eps_val;
    eps_now = 16'h0001;
    foreach (chan_mult[i]) begin
      chan_mult[i]   = '0;
      chan_offset[i] = '0;
    end

    // Tables come up zero: any sample gives zero
    add_sample(6'd0,  16'h7FFF, 1'b1, 16'h0000, 1'b0);
    add_sample(6'd63, 16'h8000, 1'b1, 16'h0000, 1'b0);
    // Unit gain, unit variance, small eps
    add_load(6'd0, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
    add_sample(6'd0, 16'h7FFF);
    add_sample(6'd0, 16'h8000);
    // Largest gain over the smallest variance: offset clips
    add_load(6'd63, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000);
    add_sample(6'd63, 16'h7FFF);
    add_sample(6'd63, 16'h8000);
    // Most negative gain, bias, largest average and variance
    add_load(6'd1, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
    add_sample(6'd1, 16'h0000);
    add_sample(6'd1, 16'h4000);
    // Zero gain leaves only the bias
    add_load(6'd2, 16'h0000, 16'h1234, 16'h5555, 16'h2AAA);
    add_sample(6'd2, 16'hAAAA);
    // Zero eps and zero variance: multiplier pins to its limits
    add_eps(16'h0000);
    add_load(6'd3, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    add_sample(6'd3, 16'h0100, 1'b1, 16'h7FFF, 1'b1);
    add_sample(6'd3, 16'h0000, 1'b1, 16'h0000, 1'b0);
    add_load(6'd4, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    add_sample(6'd4, 16'h0100, 1'b1, 16'h8000, 1'b1);
    add_load(6'd5, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_sample(6'd5, 16'h7FFF, 1'b1, 16'h0000, 1'b0);
    // Largest eps
    add_eps(16'hFFFF);
    add_load(6'd6, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF);
    add_sample(6'd6, 16'h7FFF);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling
    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].kind == RowCfg) write_eps(stim_tbl[i].eps);
      else                            drive_beat(stim_tbl[i]);
    end

    // Random part over several eps settings; idle nowhere in the last one
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       eps_val = 16'($urandom_range(16'hFFFF));
        1:       eps_val = 16'h0000;
        2:       eps_val = 16'hFFFF;
        default: eps_val = 16'h0001;
      endcase
      write_eps(eps_val);
      src_gap_pct    = (ph == 2) ? 0 : $urandom_range(40, 10);
      sink_stall_pct = (ph == 2) ? 5 : $urandom_range(40, 10);
      calm           = (ph == 3);
      // back the unit up: the sender keeps offering while results wait
      if (ph == 0) hold_req = 1'b1;
      repeat (RandBeats) drive_beat(random_beat(ph == 1));
    end

    s_axis_tvalid <= 1'b0;
    while (pending_norm.size() != 0) @(posedge clk_i);
    repeat (LoadQuiet) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10ms;
    $display("TIMEOUT: run did not finish");
    $display("Some tests failed");
    $finish;
  end

endmodule
